[rtl/core/wmms_pkg.sv]
`timescale 1ns / 1ps

package wmms_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_WINDOW_DEPTH = 64;
    localparam int DEF_CHANNELS     = 4;

    // Fixed field widths
    localparam int SAMPLE_W  = 24;
    localparam int MIN_W     = 20;
    localparam int COUNT_W   = 7;
    localparam int CHAN_W    = 2;
    localparam int WLEN_W    = 7;
    localparam int QUO_W     = 24;
    localparam int DIV_CNT_W = 5;

    localparam logic [WLEN_W-1:0]    WLEN_RESET = 7'd60;
    localparam logic [MIN_W-1:0]     MIN_START  = 20'd1000000;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS  = 5'd24;

    // Item opcodes
    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    typedef struct packed {
        logic                action;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample_us;
    } req_item_t;

    typedef struct packed {
        logic [MIN_W-1:0]    min_us;
        logic [SAMPLE_W-1:0] mean_us;
        logic [SAMPLE_W-1:0] max_us;
        logic [COUNT_W-1:0]  count;
    } rsp_item_t;

    // Microprogram addresses
    typedef enum logic [3:0] {
        S_FETCH    = 4'd0,
        S_CHK_CH   = 4'd1,
        S_CHK_OP   = 4'd2,
        S_TRIM     = 4'd3,
        S_APPEND   = 4'd4,
        S_LOAD     = 4'd5,
        S_READ0    = 4'd6,
        S_ACC      = 4'd7,
        S_DIV_INIT = 4'd8,
        S_DIV      = 4'd9,
        S_EMIT     = 4'd10,
        S_EMPTY    = 4'd11
    } step_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_REQ,
        C_BAD_CH,
        C_REPORT,
        C_HELD_ZERO,
        C_MORE,
        C_DIV_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  accept;
        logic  trim;
        logic  append;
        logic  load;
        logic  read;
        logic  acc;
        logic  div_init;
        logic  div_step;
        logic  clear;
        logic  emit;
        logic  last;
        cond_t cond;
        step_t target;
    } ctl_t;

    typedef struct packed {
        logic req_valid;
        logic bad_ch;
        logic report;
        logic held_zero;
        logic more;
        logic div_more;
        logic out_busy;
    } status_t;

    // Control store: one word per step
    function automatic ctl_t ucode_rom(step_t step);
        ctl_t w;
        w        = '0;
        w.cond   = C_NONE;
        w.target = S_FETCH;
        unique case (step)
            S_FETCH:
            begin
                w.accept = 1'b1;
                w.cond   = C_NO_REQ;
                w.target = S_FETCH;
            end
            S_CHK_CH:
            begin
                w.cond   = C_BAD_CH;
                w.target = S_EMPTY;
            end
            S_CHK_OP:
            begin
                w.cond   = C_REPORT;
                w.target = S_LOAD;
            end
            S_TRIM:
            begin
                w.trim = 1'b1;
            end
            S_APPEND:
            begin
                w.append = 1'b1;
            end
            S_LOAD:
            begin
                w.load   = 1'b1;
                w.cond   = C_HELD_ZERO;
                w.target = S_EMPTY;
            end
            S_READ0:
            begin
                w.read = 1'b1;
            end
            S_ACC:
            begin
                w.acc    = 1'b1;
                w.read   = 1'b1;
                w.cond   = C_MORE;
                w.target = S_ACC;
            end
            S_DIV_INIT:
            begin
                w.div_init = 1'b1;
            end
            S_DIV:
            begin
                w.div_step = 1'b1;
                w.cond     = C_DIV_MORE;
                w.target   = S_DIV;
            end
            S_EMIT:
            begin
                w.emit   = 1'b1;
                w.last   = 1'b1;
                w.cond   = C_OUT_BUSY;
                w.target = S_EMIT;
            end
            S_EMPTY:
            begin
                w.clear  = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = S_EMIT;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = S_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

[rtl/core/window_min_mean_max_stats.sv]
`timescale 1ns / 1ps
// Channel   Handshake               Payload                       Direction
// req       req_valid / req_stall   wmms_pkg::req_item_t req      in
// rsp       rsp_valid / rsp_stall   wmms_pkg::rsp_item_t rsp      out
// cfg       cfg_wr_en               cfg_wr_data (window length)   in
//
// One beat at a time. A record beat trims if needed and appends, then, like a
// report, walks the samples held and divides their sum; a report on an empty
// channel and a beat on an unknown channel skip the walk and the divide and emit
// an all-zero result. The walk makes one memory read per cycle over the single
// read port, and the 24-step restoring divider produces the mean.
// Reset clears the window length to 60 and all heads and counts; the sample store
// is not cleared, since only written slots are ever read.
// req_stall is high except in the fetch step; a result held under rsp_stall does
// not block fetch or processing of the next beat, only that beat's emit waits.

module window_min_mean_max_stats #(
    parameter int WINDOW_DEPTH = wmms_pkg::DEF_WINDOW_DEPTH,
    parameter int CHANNELS     = wmms_pkg::DEF_CHANNELS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  wmms_pkg::req_item_t         req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output wmms_pkg::rsp_item_t         rsp,
    input  logic                        cfg_wr_en,
    input  logic [wmms_pkg::WLEN_W-1:0] cfg_wr_data
);
    import wmms_pkg::*;

    // Control word from the microprogram and status back from the datapath
    ctl_t    ctl;
    status_t stat;

    // Sequencer: step counter, control store, conditional jumps
    wmms_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // Datapath: per-channel head/count, sample memory, accumulators, divider,
    // output register
    wmms_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .CHANNELS     (CHANNELS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req         (req),
        .rsp_stall   (rsp_stall),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctl         (ctl),
        .stat        (stat),
        .rsp_valid   (rsp_valid),
        .rsp         (rsp)
    );

    // Hold off new beats outside the fetch step
    assign req_stall = !ctl.accept;

endmodule

[rtl/core/wmms_seq.sv]
`timescale 1ns / 1ps

module wmms_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  wmms_pkg::status_t stat,
    output wmms_pkg::ctl_t    ctl
);
    import wmms_pkg::*;

    step_t      step_reg;
    step_t      step_next;
    logic       jump;
    logic [3:0] step_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        ctl = ucode_rom(step_reg);
    end

    always_comb
    begin
        unique case (ctl.cond)
            C_NONE:      jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_NO_REQ:    jump = !stat.req_valid;
            C_BAD_CH:    jump = stat.bad_ch;
            C_REPORT:    jump = stat.report;
            C_HELD_ZERO: jump = stat.held_zero;
            C_MORE:      jump = stat.more;
            C_DIV_MORE:  jump = stat.div_more;
            C_OUT_BUSY:  jump = stat.out_busy;
            default:     jump = 1'b0;
        endcase
    end

    always_comb
    begin
        step_inc = 4'(step_reg) + 4'd1;
        priority if (jump)
        begin
            step_next = ctl.target;
        end
        else if (ctl.last)
        begin
            step_next = S_FETCH;
        end
        else
        begin
            step_next = step_t'(step_inc);
        end
    end

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept && stat.req_valid |=> step_reg == S_CHK_CH)
        else $error("accepted beat did not advance to channel check");

    a_emit_returns: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit && !stat.out_busy |=> step_reg == S_FETCH)
        else $error("sequencer did not return to fetch after emit");

    a_step_legal: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= S_EMPTY)
        else $error("sequencer left the microprogram");

endmodule

[rtl/core/wmms_dp.sv]
`timescale 1ns / 1ps

module wmms_dp #(
    parameter int WINDOW_DEPTH = wmms_pkg::DEF_WINDOW_DEPTH,
    parameter int CHANNELS     = wmms_pkg::DEF_CHANNELS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  wmms_pkg::req_item_t                 req,
    input  logic                                rsp_stall,
    input  logic                                cfg_wr_en,
    input  logic [wmms_pkg::WLEN_W-1:0]         cfg_wr_data,
    input  wmms_pkg::ctl_t                      ctl,
    output wmms_pkg::status_t                   stat,
    output logic                                rsp_valid,
    output wmms_pkg::rsp_item_t                 rsp
);
    import wmms_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int WR_W   = CNT_W + 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHX_W  = (CH_W > CHAN_W) ? CH_W : CHAN_W;
    localparam int TOTAL  = CHANNELS * WINDOW_DEPTH;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int LEN_W  = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

    // Sample store, one WINDOW_DEPTH slice per channel
    logic [SAMPLE_W-1:0] store_mem [TOTAL];

    req_item_t           item_reg;
    logic [WLEN_W-1:0]   wlen_reg;
    logic [IDX_W-1:0]    oldest_reg [CHANNELS];
    logic [IDX_W-1:0]    oldest_next [CHANNELS];
    logic [CNT_W-1:0]    held_reg [CHANNELS];
    logic [CNT_W-1:0]    held_next [CHANNELS];
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [MIN_W-1:0]    mn_reg, mn_next;
    logic [SAMPLE_W-1:0] mx_reg, mx_next;
    logic [SAMPLE_W-1:0] rdata_reg;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    rsp_item_t           rsp_reg;
    logic                rsp_valid_reg, rsp_valid_next;

    logic [CHX_W-1:0]    chx;
    logic [CH_W-1:0]     ch_idx;
    logic [CNT_W-1:0]    held_cur;
    logic [IDX_W-1:0]    oldest_cur;
    logic [LEN_W-1:0]    wl_ext, len_w;
    logic [CNT_W-1:0]    len;
    logic                need_trim;
    logic [CNT_W-1:0]    drop;
    logic [WR_W-1:0]     adv, adv_w, padd, padd_w;
    logic [IDX_W-1:0]    pos;
    logic [ADDR_W-1:0]   base, wr_addr, rd_addr;
    logic                more, rd_fire, out_busy, emit_fire;
    logic [WR_W-1:0]     trial, diff;
    logic                ge;

    assign chx        = CHX_W'(item_reg.channel);
    assign ch_idx     = chx[CH_W-1:0];
    assign held_cur   = held_reg[ch_idx];
    assign oldest_cur = oldest_reg[ch_idx];

    // Window length clamped to 1..WINDOW_DEPTH
    always_comb
    begin
        wl_ext = LEN_W'(wlen_reg);
        priority if (wlen_reg == '0)
        begin
            len_w = LEN_W'(1);
        end
        else if (wl_ext > LEN_W'(WINDOW_DEPTH))
        begin
            len_w = LEN_W'(WINDOW_DEPTH);
        end
        else
        begin
            len_w = wl_ext;
        end
        len = len_w[CNT_W-1:0];
    end

    // Trim: drop enough oldest samples in one step, then wrap the head
    always_comb
    begin
        need_trim = held_cur >= len;
        drop      = held_cur - len + CNT_W'(1);
        adv       = WR_W'(oldest_cur) + WR_W'(drop);
        adv_w     = (adv >= WR_W'(WINDOW_DEPTH)) ? adv - WR_W'(WINDOW_DEPTH) : adv;
        padd      = WR_W'(oldest_cur) + WR_W'(held_cur);
        padd_w    = (padd >= WR_W'(WINDOW_DEPTH)) ? padd - WR_W'(WINDOW_DEPTH) : padd;
        pos       = padd_w[IDX_W-1:0];
    end

    assign base    = ADDR_W'(ch_idx) * ADDR_W'(WINDOW_DEPTH);
    assign wr_addr = base + ADDR_W'(pos);
    assign rd_addr = base + ADDR_W'(ptr_reg);

    assign more      = i_reg != n_reg;
    assign rd_fire   = ctl.read && more;
    assign out_busy  = rsp_valid_reg && rsp_stall;
    assign emit_fire = ctl.emit && !out_busy;

    // Restoring divide step
    always_comb
    begin
        trial = {rem_reg, quo_reg[QUO_W-1]};
        diff  = trial - {1'b0, n_reg};
        ge    = trial >= {1'b0, n_reg};
    end

    always_comb
    begin
        stat.req_valid = req_valid;
        stat.bad_ch    = int'(item_reg.channel) >= CHANNELS;
        stat.report    = item_reg.action == ACT_REPORT;
        stat.held_zero = held_cur == '0;
        stat.more      = more;
        stat.div_more  = div_cnt_reg != DIV_CNT_W'(1);
        stat.out_busy  = out_busy;
    end

    // Per-channel head and count
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            oldest_next[c] = oldest_reg[c];
            held_next[c]   = held_reg[c];
        end
        if (ctl.trim && need_trim)
        begin
            oldest_next[ch_idx] = adv_w[IDX_W-1:0];
            held_next[ch_idx]   = len - CNT_W'(1);
        end
        if (ctl.append)
        begin
            held_next[ch_idx] = held_cur + CNT_W'(1);
        end
    end

    // Walk, accumulate and divide
    always_comb
    begin
        n_next       = n_reg;
        i_next       = i_reg;
        ptr_next     = ptr_reg;
        sum_next     = sum_reg;
        mn_next      = mn_reg;
        mx_next      = mx_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        div_cnt_next = div_cnt_reg;
        if (ctl.load)
        begin
            n_next   = held_cur;
            i_next   = '0;
            ptr_next = oldest_cur;
            sum_next = '0;
            mn_next  = MIN_START;
            mx_next  = '0;
        end
        if (rd_fire)
        begin
            i_next   = i_reg + CNT_W'(1);
            ptr_next = (ptr_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + IDX_W'(1);
        end
        if (ctl.acc)
        begin
            sum_next = sum_reg + SUM_W'(rdata_reg);
            if (rdata_reg < SAMPLE_W'(mn_reg))
            begin
                mn_next = rdata_reg[MIN_W-1:0];
            end
            if (rdata_reg > mx_reg)
            begin
                mx_next = rdata_reg;
            end
        end
        if (ctl.div_init)
        begin
            rem_next     = sum_reg[SUM_W-1:QUO_W];
            quo_next     = sum_reg[QUO_W-1:0];
            div_cnt_next = DIV_STEPS;
        end
        if (ctl.div_step)
        begin
            rem_next     = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next     = {quo_reg[QUO_W-2:0], ge};
            div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
        end
        if (ctl.clear)
        begin
            n_next   = '0;
            mn_next  = '0;
            mx_next  = '0;
            quo_next = '0;
        end
    end

    always_comb
    begin
        priority if (emit_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= WLEN_RESET;
            rsp_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                oldest_reg[c] <= '0;
                held_reg[c]   <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                wlen_reg <= cfg_wr_data;
            end
            rsp_valid_reg <= rsp_valid_next;
            oldest_reg    <= oldest_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept && req_valid)
        begin
            item_reg <= req;
        end
        n_reg       <= n_next;
        i_reg       <= i_next;
        ptr_reg     <= ptr_next;
        sum_reg     <= sum_next;
        mn_reg      <= mn_next;
        mx_reg      <= mx_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        div_cnt_reg <= div_cnt_next;
        if (emit_fire)
        begin
            rsp_reg.min_us  <= mn_reg;
            rsp_reg.mean_us <= quo_reg;
            rsp_reg.max_us  <= mx_reg;
            rsp_reg.count   <= COUNT_W'(n_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.append)
        begin
            store_mem[wr_addr] <= item_reg.sample_us;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_fire)
        begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_held_chk
        a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
            held_reg[g] <= CNT_W'(WINDOW_DEPTH))
            else $error("held count exceeds window depth");
    end

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.count != '0 |-> SAMPLE_W'(rsp_reg.min_us) <= rsp_reg.max_us)
        else $error("reported min above max");

    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.count != '0 |->
            SAMPLE_W'(rsp_reg.min_us) <= rsp_reg.mean_us && rsp_reg.mean_us <= rsp_reg.max_us)
        else $error("reported mean outside min..max");

endmodule

[tb/sv/tb_window_min_mean_max_stats.sv]
`timescale 1ns / 1ps

module tb_window_min_mean_max_stats;

    import wmms_pkg::*;

    localparam int WIN_DEPTH   = DEF_WINDOW_DEPTH;
    localparam int NUM_CH      = DEF_CHANNELS;
    localparam int HEAD_W      = $clog2(WIN_DEPTH);
    // One beat never needs more than a 64-sample walk plus the divider, so this
    // is many times the slowest legal run with all stalls.
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 400;   // receiver hold-off that backs up the block
    localparam int SETTLE      = 4;     // quiet cycles before a register write
    localparam int TAIL_CYCLES = 120;   // watch for stray results at the end
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 70;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    req_item_t           req;
    logic                rsp_valid;
    logic                rsp_stall;
    rsp_item_t           rsp;
    logic                cfg_wr_en;
    logic [WLEN_W-1:0]   cfg_wr_data;

    // Shadow of the block's state, advanced once per accepted beat.
    logic [SAMPLE_W-1:0] ring_mem  [NUM_CH][WIN_DEPTH];
    logic [HEAD_W-1:0]   ring_head [NUM_CH];
    logic [COUNT_W-1:0]  ring_fill [NUM_CH];
    logic [WLEN_W-1:0]   len_reg;

    // Statistics still owed by the block, oldest first.
    rsp_item_t           pending_stats[$];
    int unsigned         mismatch_count;

    // One row of the directed drill: optional register write, then one beat.
    typedef struct {
        bit                set_len;
        logic [WLEN_W-1:0] len_value;
        req_item_t         beat;
        bit                typed;
        rsp_item_t         want;
    } drill_row_t;

    drill_row_t          drill_rows[$];

    window_min_mean_max_stats #(
        .WINDOW_DEPTH (WIN_DEPTH),
        .CHANNELS     (NUM_CH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Apply one beat to the shadow state and return the statistics it yields.
    // A record first drops the oldest samples until fewer than the (clamped)
    // window length remain, then appends. A report never trims.
    function automatic rsp_item_t window_stats_after(req_item_t beat);
        rsp_item_t           stats;
        int unsigned         ch;
        int unsigned         keep;
        int unsigned         slot;
        int unsigned         i;
        longint unsigned     total;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] v;
        stats = '0;
        ch    = beat.channel;
        if (ch >= NUM_CH)
            return stats;
        keep = len_reg;
        if (keep < 1)
            keep = 1;
        if (keep > WIN_DEPTH)
            keep = WIN_DEPTH;
        if (beat.action == ACT_RECORD)
        begin
            while (ring_fill[ch] >= keep)
            begin
                ring_head[ch] = ring_head[ch] + 1'b1;
                ring_fill[ch] = ring_fill[ch] - 1'b1;
            end
            slot = (int'(ring_head[ch]) + int'(ring_fill[ch])) % WIN_DEPTH;
            ring_mem[ch][slot] = beat.sample_us;
            ring_fill[ch]      = ring_fill[ch] + 1'b1;
        end
        if (ring_fill[ch] == 0)
            return stats;
        total = 0;
        lo    = SAMPLE_W'(MIN_START);
        hi    = '0;
        for (i = 0; i < ring_fill[ch]; i++)
        begin
            v     = ring_mem[ch][(int'(ring_head[ch]) + i) % WIN_DEPTH];
            total = total + v;
            if (v < lo)
                lo = v;
            if (v > hi)
                hi = v;
        end
        stats.min_us  = lo[MIN_W-1:0];
        stats.mean_us = SAMPLE_W'(total / ring_fill[ch]);
        stats.max_us  = hi;
        stats.count   = ring_fill[ch];
        return stats;
    endfunction

    task automatic check_field(input string field, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic row(input bit set_len, input int len, input logic act, input int ch,
                       input int sample, input bit typed, input int mn, input int mean,
                       input int mx, input int cnt);
        drill_row_t r;
        r.set_len           = set_len;
        r.len_value         = WLEN_W'(len);
        r.beat.action       = act;
        r.beat.channel      = CHAN_W'(ch);
        r.beat.sample_us    = SAMPLE_W'(sample);
        r.typed             = typed;
        r.want.min_us       = MIN_W'(mn);
        r.want.mean_us      = SAMPLE_W'(mean);
        r.want.max_us       = SAMPLE_W'(mx);
        r.want.count        = COUNT_W'(cnt);
        drill_rows          = {drill_rows, r};
    endtask

    // Offer one beat after an idle gap; hold it until the block takes it. Valid is
    // left high on return so a zero-gap follower keeps it up without a glitch.
    task automatic send_beat(input req_item_t beat, input int gap, input bit typed,
                             input rsp_item_t want);
        rsp_item_t model;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        // Run the shadow even for typed rows so its state keeps in step.
        model = window_stats_after(beat);
        pending_stats = {pending_stats, (typed ? want : model)};
    endtask

    // Write the window length only with the block idle: drop valid, drain every
    // owed result, settle, then pulse the write enable for one edge.
    task automatic write_window_length(input logic [WLEN_W-1:0] value);
        req_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        len_reg      = value;
    endtask

    // Result side: per result, draw a random stall, counted down only while valid is
    // high (none in calm stretches). Once, after 150 results, apply the LONG_HOLD
    // hold-off so the block keeps a result parked and backs up the request side.
    initial
    begin : result_sink
        int        hold_left;
        int        long_left;
        int        taken;
        bit        rx_calm;
        rsp_item_t want;
        rsp_stall <= 1'b1;
        hold_left  = 0;
        long_left  = 0;
        taken      = 0;
        rx_calm    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_stats.size() == 0)
                begin
                    $error("result beat with nothing owed: min %0d mean %0d max %0d count %0d",
                           rsp.min_us, rsp.mean_us, rsp.max_us, rsp.count);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_stats[0];
                    pending_stats.delete(0);
                    check_field("min_us", want.min_us, rsp.min_us);
                    check_field("mean_us", want.mean_us, rsp.mean_us);
                    check_field("max_us", want.max_us, rsp.max_us);
                    check_field("count", want.count, rsp.count);
                end
                taken++;
                if (taken % 25 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                hold_left = rx_calm ? 0 : $urandom_range(0, 9);
                if (taken == 150)
                    long_left = LONG_HOLD;
            end
            else if (rsp_valid && hold_left > 0)
            begin
                hold_left--;
            end
            if (long_left > 0)
                long_left--;
            rsp_stall <= (hold_left > 0) || (long_left > 0);
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned       r;
        int                phase;
        int                k;
        int                focus;
        int                len;
        bit                tx_calm;
        req_item_t         beat;
        int                phase_len [PHASES];

        rst_n       <= 1'b0;
        req_valid   <= 1'b0;
        req         <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        mismatch_count = 0;
        len_reg        = WLEN_RESET;
        for (k = 0; k < NUM_CH; k++)
        begin
            ring_head[k] = '0;
            ring_fill[k] = '0;
        end

        // Directed drill. Typed rows: empty channel, field extremes, the
        // one-million cap on min, mean truncation, report ignoring its sample,
        // a shortened window trimming only on record, length zero acting as one.
        //   set  len  action      ch sample       typed min      mean     max       cnt
        row(0, 0,   ACT_REPORT, 0, 0,           1,    0,       0,       0,        0);
        row(0, 0,   ACT_REPORT, 3, 'hFFFFFF,    1,    0,       0,       0,        0);
        row(0, 0,   ACT_RECORD, 0, 0,           1,    0,       0,       0,        1);
        row(0, 0,   ACT_RECORD, 1, 'hFFFFFF,    1,    MIN_START, 'hFFFFFF, 'hFFFFFF, 1);
        row(0, 0,   ACT_RECORD, 1, 0,           1,    0,       'h7FFFFF, 'hFFFFFF, 2);
        row(0, 0,   ACT_RECORD, 2, 1000000,     1,    1000000, 1000000, 1000000,  1);
        row(0, 0,   ACT_RECORD, 2, 999999,      1,    999999,  999999,  1000000,  2);
        row(0, 0,   ACT_RECORD, 3, 1000001,     1,    MIN_START, 1000001, 1000001, 1);
        row(0, 0,   ACT_REPORT, 3, 'hABCDEF,    1,    MIN_START, 1000001, 1000001, 1);
        row(0, 0,   ACT_RECORD, 0, 'h555555,    0,    0,       0,       0,        0);
        row(0, 0,   ACT_RECORD, 0, 'hAAAAAA,    0,    0,       0,       0,        0);
        row(0, 0,   ACT_REPORT, 1, 'h123456,    0,    0,       0,       0,        0);
        row(1, 1,   ACT_RECORD, 1, 5,           1,    5,       5,       5,        1);
        row(0, 0,   ACT_REPORT, 0, 0,           0,    0,       0,       0,        0);
        row(0, 0,   ACT_RECORD, 0, 'h7FFFFF,    1,    MIN_START, 'h7FFFFF, 'h7FFFFF, 1);
        row(1, 0,   ACT_RECORD, 2, 7,           1,    7,       7,       7,        1);
        row(0, 0,   ACT_RECORD, 2, 9,           1,    9,       9,       9,        1);
        row(0, 0,   ACT_REPORT, 2, 'hFFFFFF,    0,    0,       0,       0,        0);
        row(1, 127, ACT_RECORD, 3, 3,           1,    3,       500002,  1000001,  2);
        row(0, 0,   ACT_RECORD, 3, 'hFFFFFF,    0,    0,       0,       0,        0);
        row(1, 64,  ACT_REPORT, 1, 0,           0,    0,       0,       0,        0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < drill_rows.size(); r++)
        begin
            if (drill_rows[r].set_len)
                write_window_length(drill_rows[r].len_value);
            send_beat(drill_rows[r].beat, $urandom_range(0, 9), drill_rows[r].typed,
                      drill_rows[r].want);
        end

        // Random phases. Each phase picks a window length; three phases in a row
        // lean on one channel so its window fills, wraps, and is then cut short.
        phase_len = '{64, 127, 3, 0, 64, 1, 65, 16, 2, 0};
        for (phase = 0; phase < PHASES; phase++)
        begin
            len = (phase == PHASES - 1) ? $urandom_range(0, 127) : phase_len[phase];
            write_window_length(WLEN_W'(len));
            focus   = (phase / 3) % NUM_CH;
            tx_calm = 1'b0;
            for (k = 0; k < PHASE_BEATS; k++)
            begin
                if (k % 20 == 0)
                    tx_calm = ($urandom_range(0, 3) == 0);
                beat.channel = CHAN_W'(($urandom_range(0, 3) != 0) ?
                                       focus : $urandom_range(0, 3));
                beat.action  = ($urandom_range(0, 4) == 0) ? ACT_REPORT : ACT_RECORD;
                case ($urandom_range(0, 7))
                    0:       beat.sample_us = '1;
                    1:       beat.sample_us = SAMPLE_W'(SAMPLE_W'(MIN_START) - 1 +
                                                        $urandom_range(0, 2));
                    2:       beat.sample_us = SAMPLE_W'($urandom_range(0, 15));
                    3, 4:    beat.sample_us = SAMPLE_W'($urandom_range(900000, 1100000));
                    default: beat.sample_us = SAMPLE_W'($urandom());
                endcase
                send_beat(beat, tx_calm ? 0 : $urandom_range(0, 9), 1'b0, '0);
            end
        end

        // Drain, then keep watching a while for any stray result.
        req_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_stats.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
